/* sv/assert_macros.svh */
// Assertion macros for the execute top, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mie_pkg.sv */
// Types and constants shared by the MOV immediate execute block.
package mie_pkg;

    localparam logic [1:0] MODE_NODISP = 2'd0;
    localparam logic [1:0] MODE_DISP8  = 2'd1;
    localparam logic [1:0] MODE_DISP32 = 2'd2;
    localparam logic [1:0] MODE_REG    = 2'd3;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    localparam logic [2:0] RM_SIB      = 3'd4;
    localparam logic [2:0] RM_DISP32   = 3'd5;
    localparam logic [2:0] BASE_DISP32 = 3'd5;
    localparam logic [2:0] INDEX_NONE  = 3'd4;

    localparam logic       FUNC_MOV  = 1'b0;
    localparam logic       FUNC_LOAD = 1'b1;

    localparam logic [31:0] KEEP_HI24   = 32'hffffff00;
    localparam logic [31:0] BYTE_LO     = 32'h000000ff;
    localparam logic [31:0] KEEP_NOT_HB = 32'hffff00ff;
    localparam logic [31:0] BYTE_HI     = 32'h0000ff00;
    localparam logic [31:0] KEEP_HI16   = 32'hffff0000;
    localparam logic [31:0] WORD_LO     = 32'h0000ffff;

    // Decoded instruction as it travels through the pipeline.
    typedef struct packed {
        logic        func;
        logic [1:0]  addr_mode;
        logic [2:0]  rm_field;
        logic [1:0]  sib_scale;
        logic [2:0]  sib_index;
        logic [2:0]  sib_base;
        logic [31:0] displacement;
        logic [31:0] immediate;
        logic        wide;
        logic        operand_16;
    } mie_inst_t;

    typedef struct packed {
        logic        mem_write;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic [31:0] mem_data;
        logic        reg_written;
        logic [2:0]  reg_number;
        logic [31:0] reg_value;
    } mie_res_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  addr;
        logic [31:0] data;
    } mie_wr_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  addr_a;
        logic [2:0]  addr_b;
    } mie_rd_t;

endpackage

/* sv/mie_if.sv */
// Request and result channel interfaces of the MOV immediate execute block.
interface mie_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [1:0]  addr_mode;
    logic [2:0]  rm_field;
    logic [1:0]  sib_scale;
    logic [2:0]  sib_index;
    logic [2:0]  sib_base;
    logic [31:0] displacement;
    logic [31:0] immediate;
    logic        wide;
    logic        operand_16;

    modport source (
        output valid, func, addr_mode, rm_field, sib_scale, sib_index, sib_base,
               displacement, immediate, wide, operand_16,
        input  ready
    );
    modport sink (
        input  valid, func, addr_mode, rm_field, sib_scale, sib_index, sib_base,
               displacement, immediate, wide, operand_16,
        output ready
    );
endinterface

interface mie_rsp_if;
    logic        valid;
    logic        ready;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [31:0] mem_data;
    logic        reg_written;
    logic [2:0]  reg_number;
    logic [31:0] reg_value;

    modport source (
        output valid, mem_write, mem_address, mem_size, mem_data, reg_written,
               reg_number, reg_value,
        input  ready
    );
    modport sink (
        input  valid, mem_write, mem_address, mem_size, mem_data, reg_written,
               reg_number, reg_value,
        output ready
    );
endinterface

/* sv/x86_mov_imm_execute_top.sv */
// Executes decoded MOV r/m,imm instructions against an eight-entry register file.
//
// Channel cmd carries one decoded instruction per request: the function
// (execute or register load), ModRM mode and rm, the SIB fields, the
// displacement, the immediate and the operand size bits. Channel rsp carries
// one result per request: either a memory write (address, size, data) or the
// register that changed and its new full value.
// The edge that accepts a request loads the execute stage register and reads the
// register file memory; when the execute stage advances, the address or merge is
// computed, the register is written back and the output register is loaded.
// Throughput is one request per cycle while rsp is not stalled. The register file
// memory has two read ports and one write port; a one-entry bypass of the newest
// write serves a request whose read overlaps the write of the request just ahead.
// Reset clears all eight registers to zero at once (per-entry valid bits), so
// requests are taken from the first cycle after reset.
// When the receiver stalls, the output register holds its result and the
// execute stage fills behind it; cmd.ready falls only when both are full.
`include "assert_macros.svh"

module x86_mov_imm_execute_top
    import mie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mie_req_if.sink   cmd,
    mie_rsp_if.source rsp
);

    mie_inst_t   inst_in;
    mie_inst_t   s1_inst_reg;
    logic        s1_vld_reg;
    logic        s1_adv;
    logic        cmd_fire;
    mie_rd_t     rd;
    mie_wr_t     wr;
    logic [31:0] data_a;
    logic [31:0] data_b;
    mie_res_t    res;
    mie_res_t    out_reg;
    logic        out_vld_reg;

    always_comb
    begin
        inst_in.func         = cmd.func;
        inst_in.addr_mode    = cmd.addr_mode;
        inst_in.rm_field     = cmd.rm_field;
        inst_in.sib_scale    = cmd.sib_scale;
        inst_in.sib_index    = cmd.sib_index;
        inst_in.sib_base     = cmd.sib_base;
        inst_in.displacement = cmd.displacement;
        inst_in.immediate    = cmd.immediate;
        inst_in.wide         = cmd.wide;
        inst_in.operand_16   = cmd.operand_16;
    end

    assign s1_adv    = s1_vld_reg && (!out_vld_reg || rsp.ready);
    assign cmd.ready = !s1_vld_reg || s1_adv;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Byte register mode addresses entries 0..3 for both low and high bytes.
    always_comb
    begin
        rd.en     = cmd_fire;
        rd.addr_b = cmd.sib_index;
        if (cmd.func == FUNC_MOV && cmd.addr_mode != MODE_REG && cmd.rm_field == RM_SIB)
            rd.addr_a = cmd.sib_base;
        else if (cmd.func == FUNC_MOV && cmd.addr_mode == MODE_REG && !cmd.wide)
            rd.addr_a = {1'b0, cmd.rm_field[1:0]};
        else
            rd.addr_a = cmd.rm_field;
    end

    mie_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rd),
        .wr     (wr),
        .data_a (data_a),
        .data_b (data_b)
    );

    mie_exec u_exec (
        .inst   (s1_inst_reg),
        .data_a (data_a),
        .data_b (data_b),
        .res    (res)
    );

    always_comb
    begin
        wr.en   = s1_adv && res.reg_written;
        wr.addr = res.reg_number;
        wr.data = res.reg_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
                s1_vld_reg <= cmd.valid;
            if (s1_adv)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            s1_inst_reg <= inst_in;
        if (s1_adv)
            out_reg <= res;
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.mem_write   = out_reg.mem_write;
    assign rsp.mem_address = out_reg.mem_address;
    assign rsp.mem_size    = out_reg.mem_size;
    assign rsp.mem_data    = out_reg.mem_data;
    assign rsp.reg_written = out_reg.reg_written;
    assign rsp.reg_number  = out_reg.reg_number;
    assign rsp.reg_value   = out_reg.reg_value;

    `ASSERT_IMPLIES(a_one_kind, rsp.valid, rsp.mem_write != rsp.reg_written,
        "result must be exactly one of memory write or register update")
    `ASSERT_IMPLIES(a_mem_zero, rsp.valid && !rsp.mem_write,
        rsp.mem_address == 32'd0 && rsp.mem_size == SIZE_BYTE && rsp.mem_data == 32'd0,
        "memory fields must be zero without a write")
    `ASSERT_IMPLIES(a_wr_only_adv, wr.en, s1_adv,
        "register file written while execute stage is stalled")
    `ASSERT_NEXT(a_fire_fills, cmd_fire, s1_vld_reg,
        "accepted request did not enter the execute stage")

endmodule

/* sv/mie_regfile.sv */
// Eight-entry register file memory with two read ports and write bypass.
module mie_regfile
    import mie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mie_rd_t     rd,
    input  mie_wr_t     wr,
    output logic [31:0] data_a,
    output logic [31:0] data_b
);

    logic [31:0] mem [8];
    logic [31:0] q_a_reg;
    logic [31:0] q_b_reg;
    logic [7:0]  vld_reg;
    logic        vld_a_reg;
    logic        vld_b_reg;
    logic [2:0]  addr_a_reg;
    logic [2:0]  addr_b_reg;
    logic        lw_vld_reg;
    logic [2:0]  lw_addr_reg;
    logic [31:0] lw_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            q_a_reg <= mem[rd.addr_a];
            q_b_reg <= mem[rd.addr_b];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            vld_a_reg  <= 1'b0;
            vld_b_reg  <= 1'b0;
            addr_a_reg <= '0;
            addr_b_reg <= '0;
            lw_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
                lw_vld_reg       <= 1'b1;
            end
            if (rd.en)
            begin
                vld_a_reg  <= vld_reg[rd.addr_a];
                vld_b_reg  <= vld_reg[rd.addr_b];
                addr_a_reg <= rd.addr_a;
                addr_b_reg <= rd.addr_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            lw_addr_reg <= wr.addr;
            lw_data_reg <= wr.data;
        end
    end

    // The last write is always the newest value of its entry, so it may
    // override the memory output whether it landed before or with the read.
    always_comb
    begin
        if (lw_vld_reg && lw_addr_reg == addr_a_reg)
            data_a = lw_data_reg;
        else
            data_a = vld_a_reg ? q_a_reg : '0;
        if (lw_vld_reg && lw_addr_reg == addr_b_reg)
            data_b = lw_data_reg;
        else
            data_b = vld_b_reg ? q_b_reg : '0;
    end

endmodule

/* sv/mie_exec.sv */
// Address generation and register merge for one instruction.
module mie_exec
    import mie_pkg::*;
(
    input  mie_inst_t   inst,
    input  logic [31:0] data_a,
    input  logic [31:0] data_b,
    output mie_res_t    res
);

    logic [1:0]  size;
    logic [31:0] disp;
    logic [31:0] base_val;
    logic [31:0] index_val;
    logic [31:0] merged;
    logic [2:0]  reg_num;
    logic [31:0] data_mask;

    always_comb
    begin
        size = inst.wide ? (inst.operand_16 ? SIZE_WORD : SIZE_DWORD) : SIZE_BYTE;

        case (inst.addr_mode)
            MODE_DISP8:  disp = {{24{inst.displacement[7]}}, inst.displacement[7:0]};
            MODE_DISP32: disp = inst.displacement;
            default:     disp = '0;
        endcase

        if (inst.addr_mode == MODE_NODISP &&
            ((inst.rm_field == RM_DISP32) ||
             (inst.rm_field == RM_SIB && inst.sib_base == BASE_DISP32)))
            base_val = inst.displacement;
        else
            base_val = data_a + disp;

        if (inst.rm_field == RM_SIB && inst.sib_index != INDEX_NONE)
            index_val = data_b << inst.sib_scale;
        else
            index_val = '0;

        // High byte registers AH..BH live in bits 15:8 of entries 0..3.
        reg_num = inst.rm_field;
        case (size)
            SIZE_BYTE:
            begin
                reg_num = {1'b0, inst.rm_field[1:0]};
                if (!inst.rm_field[2])
                    merged = (data_a & KEEP_HI24) | (inst.immediate & BYTE_LO);
                else
                    merged = (data_a & KEEP_NOT_HB) | ((inst.immediate << 8) & BYTE_HI);
            end
            SIZE_WORD: merged = (data_a & KEEP_HI16) | (inst.immediate & WORD_LO);
            default:   merged = inst.immediate;
        endcase

        case (size)
            SIZE_BYTE: data_mask = BYTE_LO;
            SIZE_WORD: data_mask = WORD_LO;
            default:   data_mask = '1;
        endcase

        res = '0;
        if (inst.func == FUNC_LOAD)
        begin
            res.reg_written = 1'b1;
            res.reg_number  = inst.rm_field;
            res.reg_value   = inst.immediate;
        end
        else if (inst.addr_mode == MODE_REG)
        begin
            res.reg_written = 1'b1;
            res.reg_number  = reg_num;
            res.reg_value   = merged;
        end
        else
        begin
            res.mem_write   = 1'b1;
            res.mem_address = base_val + index_val;
            res.mem_size    = size;
            res.mem_data    = inst.immediate & data_mask;
        end
    end

endmodule

/* dv/tb_x86_mov_imm_execute_top.sv */
// Testbench for the MOV r/m,imm execute block: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module tb_x86_mov_imm_execute_top;
    import mie_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_PER_PASS = 288;
    localparam int HOLD_CYCLES     = 64;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RUN_LIMIT       = 200000;

    typedef struct {
        mie_inst_t inst;
        bit        typed;
        mie_res_t  res;
    } vector_t;

    logic clk;
    logic rst_n;

    mie_req_if cmd_if ();
    mie_rsp_if rsp_if ();

    x86_mov_imm_execute_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // Architectural register file as the testbench expects it.
    logic [31:0] arch_regs [8];
    mie_res_t    pending_results [$];
    vector_t     directed [$];

    // Typed expectation travelling with the request on the bus.
    bit          row_typed;
    mie_res_t    row_res;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;

    int accepted;
    int mismatches;
    int mem_writes_seen;
    int reg_updates_seen;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic mie_inst_t mk_inst(input logic f, input logic [1:0] mode,
                                          input logic [2:0] rm, input logic [1:0] scale,
                                          input logic [2:0] index, input logic [2:0] base,
                                          input logic [31:0] disp, input logic [31:0] imm,
                                          input logic wide, input logic op16);
        mie_inst_t ins;
        ins.func         = f;
        ins.addr_mode    = mode;
        ins.rm_field     = rm;
        ins.sib_scale    = scale;
        ins.sib_index    = index;
        ins.sib_base     = base;
        ins.displacement = disp;
        ins.immediate    = imm;
        ins.wide         = wide;
        ins.operand_16   = op16;
        return ins;
    endfunction

    function automatic mie_res_t reg_res(input logic [2:0] num, input logic [31:0] val);
        mie_res_t r;
        r             = '0;
        r.reg_written = 1'b1;
        r.reg_number  = num;
        r.reg_value   = val;
        return r;
    endfunction

    function automatic mie_res_t mem_res(input logic [31:0] addr, input logic [1:0] size,
                                         input logic [31:0] data);
        mie_res_t r;
        r             = '0;
        r.mem_write   = 1'b1;
        r.mem_address = addr;
        r.mem_size    = size;
        r.mem_data    = data;
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input mie_inst_t ins, input bit typed, input mie_res_t res);
        vector_t v;
        v.inst  = ins;
        v.typed = typed;
        v.res   = res;
        directed.insert(directed.size(), v);
    endfunction

    // Appends one expected result to the scoreboard queue.
    function automatic void store_expected(input mie_res_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Executes one request against arch_regs and returns the result it must produce.
    function automatic mie_res_t predict_mov(input mie_inst_t ins);
        mie_res_t    r;
        logic [1:0]  size;
        logic [2:0]  dst;
        logic [31:0] disp;
        logic [31:0] addr;
        logic [31:0] mask;
        r    = '0;
        size = !ins.wide ? SIZE_BYTE : (ins.operand_16 ? SIZE_WORD : SIZE_DWORD);
        if (ins.func == FUNC_LOAD) begin
            arch_regs[ins.rm_field] = ins.immediate;
            return reg_res(ins.rm_field, ins.immediate);
        end
        if (ins.addr_mode == MODE_REG) begin
            dst = ins.rm_field;
            if (size == SIZE_BYTE) begin
                if (ins.rm_field < RM_SIB) begin
                    arch_regs[dst] = (arch_regs[dst] & KEEP_HI24) | (ins.immediate & BYTE_LO);
                end
                else begin
                    // AH..BH live in bits 15:8 of the first four registers.
                    dst = ins.rm_field - 3'd4;
                    arch_regs[dst] = (arch_regs[dst] & KEEP_NOT_HB)
                                   | ((ins.immediate << 8) & BYTE_HI);
                end
            end
            else if (size == SIZE_WORD) begin
                arch_regs[dst] = (arch_regs[dst] & KEEP_HI16) | (ins.immediate & WORD_LO);
            end
            else begin
                arch_regs[dst] = ins.immediate;
            end
            return reg_res(dst, arch_regs[dst]);
        end
        case (ins.addr_mode)
            MODE_DISP8:  disp = {{24{ins.displacement[7]}}, ins.displacement[7:0]};
            MODE_DISP32: disp = ins.displacement;
            default:     disp = 32'd0;
        endcase
        if (ins.rm_field != RM_SIB) begin
            if (ins.addr_mode == MODE_NODISP && ins.rm_field == RM_DISP32)
                addr = ins.displacement;
            else
                addr = arch_regs[ins.rm_field] + disp;
        end
        else begin
            if (ins.addr_mode == MODE_NODISP && ins.sib_base == BASE_DISP32)
                addr = ins.displacement;
            else
                addr = arch_regs[ins.sib_base] + disp;
            if (ins.sib_index != INDEX_NONE)
                addr = addr + (arch_regs[ins.sib_index] << ins.sib_scale);
        end
        mask = (size == SIZE_BYTE) ? BYTE_LO : ((size == SIZE_WORD) ? WORD_LO : 32'hffffffff);
        return mem_res(addr, size, ins.immediate & mask);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    function automatic mie_inst_t random_inst();
        mie_inst_t ins;
        int        kind;
        int        pick;
        ins.func         = FUNC_MOV;
        ins.addr_mode    = 2'($urandom_range(3));
        ins.rm_field     = 3'($urandom_range(7));
        ins.sib_scale    = 2'($urandom_range(3));
        ins.sib_index    = 3'($urandom_range(7));
        ins.sib_base     = 3'($urandom_range(7));
        ins.displacement = $urandom;
        ins.immediate    = $urandom;
        ins.wide         = 1'($urandom_range(1));
        ins.operand_16   = 1'($urandom_range(1));
        kind = $urandom_range(99);
        if (kind < 18)
            ins.func = FUNC_LOAD;
        else if (kind < 42)
            ins.addr_mode = MODE_REG;
        else begin
            ins.addr_mode = 2'($urandom_range(2));
            if ($urandom_range(99) < 45)
                ins.rm_field = RM_SIB;
        end
        pick = $urandom_range(9);
        case (pick)
            0: ins.displacement = 32'h0;
            1: ins.displacement = 32'hffffffff;
            2: ins.displacement = 32'h80000000;
            3: ins.displacement = {ins.displacement[31:8], 8'h80};
            4: ins.displacement = {ins.displacement[31:8], 8'h7f};
            default: ;
        endcase
        pick = $urandom_range(9);
        case (pick)
            0: ins.immediate = 32'h0;
            1: ins.immediate = 32'hffffffff;
            2: ins.immediate = 32'h7fffffff;
            default: ;
        endcase
        return ins;
    endfunction

    task automatic offer_request(input mie_inst_t ins, input bit typed, input mie_res_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.func         <= ins.func;
        cmd_if.addr_mode    <= ins.addr_mode;
        cmd_if.rm_field     <= ins.rm_field;
        cmd_if.sib_scale    <= ins.sib_scale;
        cmd_if.sib_index    <= ins.sib_index;
        cmd_if.sib_base     <= ins.sib_base;
        cmd_if.displacement <= ins.displacement;
        cmd_if.immediate    <= ins.immediate;
        cmd_if.wide         <= ins.wide;
        cmd_if.operand_16   <= ins.operand_16;
        row_typed           <= typed;
        row_res             <= res;
        do @(posedge clk); while (!cmd_if.ready);
    endtask

    // Request monitor and result scoreboard.
    always @(posedge clk) begin
        mie_inst_t seen;
        mie_res_t  want;
        if (rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                seen = mk_inst(cmd_if.func, cmd_if.addr_mode, cmd_if.rm_field,
                               cmd_if.sib_scale, cmd_if.sib_index, cmd_if.sib_base,
                               cmd_if.displacement, cmd_if.immediate, cmd_if.wide,
                               cmd_if.operand_16);
                want = predict_mov(seen);
                if (row_typed)
                    want = row_res;
                store_expected(want);
                accepted++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t", $realtime);
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("mem_write", 32'(want.mem_write), 32'(rsp_if.mem_write));
                    check_field("mem_address", want.mem_address, rsp_if.mem_address);
                    check_field("mem_size", 32'(want.mem_size), 32'(rsp_if.mem_size));
                    check_field("mem_data", want.mem_data, rsp_if.mem_data);
                    check_field("reg_written", 32'(want.reg_written),
                                32'(rsp_if.reg_written));
                    check_field("reg_number", 32'(want.reg_number), 32'(rsp_if.reg_number));
                    check_field("reg_value", want.reg_value, rsp_if.reg_value);
                end
                if (rsp_if.mem_write)
                    mem_writes_seen++;
                if (rsp_if.reg_written)
                    reg_updates_seen++;
            end
        end
    end

    // Result receiver; a hold request stalls it for a long counted stretch.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    rsp_if.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #(RUN_LIMIT * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int waited;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.func         = FUNC_MOV;
        cmd_if.addr_mode    = MODE_NODISP;
        cmd_if.rm_field     = '0;
        cmd_if.sib_scale    = '0;
        cmd_if.sib_index    = '0;
        cmd_if.sib_base     = '0;
        cmd_if.displacement = '0;
        cmd_if.immediate    = '0;
        cmd_if.wide         = 1'b0;
        cmd_if.operand_16   = 1'b0;
        row_typed           = 1'b0;
        row_res             = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_request        = 1'b0;
        accepted            = 0;
        mismatches          = 0;
        mem_writes_seen     = 0;
        reg_updates_seen    = 0;
        waited              = 0;
        for (int i = 0; i < 8; i++)
            arch_regs[i] = '0;

        // Register merges from the cleared file, then loads and addressing forms.
        add_row(mk_inst(FUNC_MOV, MODE_REG, 3'd0, 2'd0, 3'd0, 3'd0,
                32'h0, 32'hffffffa5, 1'b0, 1'b0), 1'b1, reg_res(3'd0, 32'h000000a5));
        add_row(mk_inst(FUNC_MOV, MODE_REG, 3'd4, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h1234565a, 1'b0, 1'b0), 1'b1, reg_res(3'd0, 32'h00005aa5));
        add_row(mk_inst(FUNC_MOV, MODE_NODISP, RM_DISP32, 2'd3, 3'd0, 3'd0,
                32'hffffffff, 32'hffffffff, 1'b1, 1'b0), 1'b1,
                mem_res(32'hffffffff, SIZE_DWORD, 32'hffffffff));
        add_row(mk_inst(FUNC_LOAD, MODE_DISP32, 3'd1, 2'd0, 3'd0, 3'd0,
                32'h0, 32'hffffffff, 1'b0, 1'b0), 1'b1, reg_res(3'd1, 32'hffffffff));
        add_row(mk_inst(FUNC_MOV, MODE_REG, 3'd1, 2'd0, 3'd0, 3'd0,
                32'h0, 32'habcd1234, 1'b1, 1'b1), 1'b1, reg_res(3'd1, 32'hffff1234));
        add_row(mk_inst(FUNC_MOV, MODE_REG, 3'd5, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h0, 1'b0, 1'b0), 1'b1, reg_res(3'd1, 32'hffff0034));
        add_row(mk_inst(FUNC_MOV, MODE_REG, 3'd7, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h80000000, 1'b1, 1'b0), 1'b1, reg_res(3'd7, 32'h80000000));
        add_row(mk_inst(FUNC_MOV, MODE_NODISP, RM_DISP32, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h0, 1'b0, 1'b0), 1'b1, mem_res(32'h0, SIZE_BYTE, 32'h0));
        add_row(mk_inst(FUNC_MOV, MODE_DISP8, 3'd1, 2'd0, 3'd0, 3'd0,
                32'h12345680, 32'h0badf00d, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk_inst(FUNC_MOV, MODE_DISP8, 3'd0, 2'd0, 3'd0, 3'd0,
                32'h0000007f, 32'hdeadbeef, 1'b1, 1'b1), 1'b0, '0);
        add_row(mk_inst(FUNC_MOV, MODE_DISP32, 3'd7, 2'd0, 3'd0, 3'd0,
                32'h80000000, 32'h13572468, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk_inst(FUNC_MOV, MODE_NODISP, 3'd3, 2'd0, 3'd0, 3'd0,
                32'h55555555, 32'hffffffff, 1'b0, 1'b1), 1'b0, '0);
        add_row(mk_inst(FUNC_LOAD, MODE_REG, 3'd4, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h7fffffff, 1'b0, 1'b0), 1'b1, reg_res(3'd4, 32'h7fffffff));
        add_row(mk_inst(FUNC_LOAD, MODE_NODISP, 3'd5, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h00001000, 1'b1, 1'b1), 1'b1, reg_res(3'd5, 32'h00001000));
        add_row(mk_inst(FUNC_MOV, MODE_NODISP, RM_SIB, 2'd3, 3'd1, BASE_DISP32,
                32'h00000100, 32'h00c0ffee, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk_inst(FUNC_MOV, MODE_DISP32, RM_SIB, 2'd2, INDEX_NONE, 3'd4,
                32'hfffffff0, 32'h24681357, 1'b1, 1'b1), 1'b0, '0);
        add_row(mk_inst(FUNC_MOV, MODE_DISP8, RM_SIB, 2'd2, 3'd7, 3'd5,
                32'h00000080, 32'h000000aa, 1'b0, 1'b0), 1'b0, '0);
        add_row(mk_inst(FUNC_MOV, MODE_NODISP, RM_SIB, 2'd3, INDEX_NONE, 3'd0,
                32'haaaaaaaa, 32'h55aa55aa, 1'b1, 1'b0), 1'b0, '0);
        // Scale is still applied when the base is replaced by a disp32.
        add_row(mk_inst(FUNC_MOV, MODE_NODISP, RM_SIB, 2'd3, 3'd5, BASE_DISP32,
                32'h13579bdf, 32'h0000ffff, 1'b1, 1'b1), 1'b0, '0);
        add_row(mk_inst(FUNC_LOAD, MODE_DISP8, 3'd2, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h89abcdef, 1'b0, 1'b0), 1'b1, reg_res(3'd2, 32'h89abcdef));
        add_row(mk_inst(FUNC_MOV, MODE_REG, 3'd6, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h00000011, 1'b0, 1'b1), 1'b0, '0);
        add_row(mk_inst(FUNC_LOAD, MODE_REG, 3'd3, 2'd0, 3'd0, 3'd0,
                32'h0, 32'hfedcba98, 1'b0, 1'b0), 1'b1, reg_res(3'd3, 32'hfedcba98));
        add_row(mk_inst(FUNC_MOV, MODE_REG, 3'd7, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h00000022, 1'b0, 1'b0), 1'b0, '0);
        // Base 3 was written by the two requests just ahead, index 2 earlier.
        add_row(mk_inst(FUNC_MOV, MODE_DISP32, RM_SIB, 2'd1, 3'd2, 3'd3,
                32'h01020304, 32'hcafef00d, 1'b0, 1'b1), 1'b0, '0);
        add_row(mk_inst(FUNC_LOAD, MODE_NODISP, 3'd6, 2'd0, 3'd0, 3'd0,
                32'h0, 32'h0, 1'b1, 1'b0), 1'b1, reg_res(3'd6, 32'h0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            offer_request(directed[i].inst, directed[i].typed, directed[i].res);

        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            repeat (RANDOM_PER_PASS)
                offer_request(random_inst(), 1'b0, '0);
        end
        cmd_if.valid <= 1'b0;
        row_typed    <= 1'b0;

        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatches += pending_results.size();

        $display("Sent %0d requests (%0d directed); %0d memory writes, %0d register updates.",
                 accepted, directed.size(), mem_writes_seen, reg_updates_seen);
        $display("Idle passes: none, sender 83%%, receiver 83%%, both 12%%; one receiver hold of %0d cycles.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
